@@ design/rkf_pkg.sv @@
// ---------------------------------------------------------------------------
// rkf_pkg: shared types and constants for the gated range filter
// Payload structs, register indexes, status codes, sequencer enums and
// saturation helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package rkf_pkg;

  localparam int WIN_DEPTH = 6;
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int WIN_CNT_W = $clog2(WIN_DEPTH + 1);

  typedef struct packed {
    logic        [31:0] elapsed_time;
    logic signed [31:0] range_sample;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] filtered_range;
  } out_item_t;

  typedef enum logic [2:0] {
    CFG_INIT_TOL    = 3'd0,
    CFG_PROC_NOISE  = 3'd1,
    CFG_MEAS_NOISE  = 3'd2,
    CFG_GATE_FACTOR = 3'd3,
    CFG_WARMUP      = 3'd4
  } cfg_idx_e;

  localparam logic [1:0] STAT_INIT   = 2'd0;
  localparam logic [1:0] STAT_REJECT = 2'd1;
  localparam logic [1:0] STAT_WARMUP = 2'd2;
  localparam logic [1:0] STAT_VALID  = 2'd3;

  localparam logic [23:0] RST_INIT_TOL   = 24'd65536;
  localparam logic [31:0] RST_PROC_NOISE = 32'd1677722;
  localparam logic [31:0] RST_MEAS_NOISE = 32'd167772160;
  localparam logic [15:0] RST_GATE       = 16'd6554;
  localparam logic [3:0]  RST_WARMUP     = 4'd10;

  localparam logic signed [47:0] Q24_ONE  = 48'sd16777216;
  localparam logic        [30:0] GAIN_MAX = 31'h7FFF_FFFF;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_LOCK, S_MUL, S_MWAIT, S_ADD, S_TRACE, S_GATE,
    S_DIV0, S_DWAIT0, S_DIV1, S_DWAIT1, S_OUT
  } st_e;

  typedef enum logic [3:0] {
    OP_DP11, OP_P01, OP_P10, OP_DDP, OP_VEL, OP_THR,
    OP_K0E, OP_K1E, OP_C00, OP_C01, OP_C10, OP_C11
  } op_e;

  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v[49:47] == {3{v[49]}}) begin
      r = v[47:0];
    end else if (v[49]) begin
      r = {1'b1, 47'd0};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v[48:31] == {18{v[48]}}) begin
      r = v[31:0];
    end else if (v[48]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/rkf_mul.sv @@
// ---------------------------------------------------------------------------
// rkf_mul: shared rounding multiplier
// Sign-magnitude 48x32 product in two 24x32 partial products, then round
// half away from zero, shift by 16 or 24 and clamp to signed 48 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module rkf_mul
  import rkf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [47:0] a_i,
  input  wire logic signed [32:0] b_i,
  input  wire logic               sh24_i,
  output logic                    done_o,
  output logic signed [47:0]      p_o
);

  logic [47:0] ma_q;
  logic [31:0] mb_q;
  logic        neg_q, sh24_q;
  logic [79:0] acc_q;
  logic [1:0]  phase_q;
  logic        done_q;
  logic signed [47:0] p_q;

  logic [47:0] ma_d;
  logic [32:0] mb_d;
  logic [80:0] rnd;
  logic [80:0] shv;
  logic [47:0] lim, mag;

  always_comb begin
    ma_d = a_i[47] ? 48'(-a_i) : 48'(a_i);
    mb_d = b_i[32] ? 33'(-b_i) : 33'(b_i);
    rnd  = {1'b0, acc_q} + (sh24_q ? 81'(1) << 23 : 81'(1) << 15);
    shv  = sh24_q ? (rnd >> 24) : (rnd >> 16);
    lim  = neg_q ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    mag  = (shv > {33'd0, lim}) ? lim : shv[47:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        phase_q <= 2'd1;
      end else if (phase_q == 2'd3) begin
        phase_q <= 2'd0;
        done_q  <= 1'b1;
      end else if (phase_q != 2'd0) begin
        phase_q <= phase_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q   <= ma_d;
      mb_q   <= mb_d[31:0];
      neg_q  <= a_i[47] ^ b_i[32];
      sh24_q <= sh24_i;
    end else if (phase_q == 2'd1) begin
      acc_q <= 80'(ma_q[23:0] * mb_q);
    end else if (phase_q == 2'd2) begin
      acc_q <= acc_q + (80'(ma_q[47:24] * mb_q) << 24);
    end else if (phase_q == 2'd3) begin
      p_q <= neg_q ? 48'(-mag) : 48'(mag);
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

`default_nettype wire

@@ design/rkf_div.sv @@
// ---------------------------------------------------------------------------
// rkf_div: Kalman gain divider
// Restoring division, one quotient bit a cycle: Q7.24 gain p/s, truncated,
// magnitude clamped.
// ---------------------------------------------------------------------------
`default_nettype none

module rkf_div
  import rkf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [47:0] p_i,
  input  wire logic        [47:0] s_i,
  output logic                    done_o,
  output logic signed [31:0]      q_o
);

  logic        busy_q, done_q, neg_q;
  logic [4:0]  cnt_q;
  logic [48:0] rem_q;
  logic [47:0] den_q;
  logic [30:0] nb_q, quot_q;

  logic [47:0] mp;
  logic        clamp;
  logic [48:0] rt;

  always_comb begin
    mp    = p_i[47] ? 48'(-p_i) : 48'(p_i);
    clamp = {7'd0, mp} >= {s_i, 7'd0};
    rt    = {rem_q[47:0], nb_q[30]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= clamp ? 5'd0 : 5'd31;
      end else if (busy_q) begin
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= p_i[47];
      den_q  <= s_i;
      rem_q  <= 49'(mp >> 7);
      nb_q   <= {mp[6:0], 24'd0};
      quot_q <= clamp ? GAIN_MAX : 31'd0;
    end else if (busy_q && cnt_q != 5'd0) begin
      nb_q <= {nb_q[29:0], 1'b0};
      if (rt >= {1'b0, den_q}) begin
        rem_q  <= rt - {1'b0, den_q};
        quot_q <= {quot_q[29:0], 1'b1};
      end else begin
        rem_q  <= rt;
        quot_q <= {quot_q[29:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? 32'(-$signed({1'b0, quot_q})) : $signed({1'b0, quot_q});

endmodule

`default_nettype wire

@@ design/range_kalman_filter_gated.sv @@
// Sequencing: before lock a request fills the window or scans it for min/max;
//   a locked update runs 12 products on the shared multiplier plus two serial
//   gain divisions; a rejection skips the divisions and the gain products.
// Throughput: one request at a time; the next is taken after the result is
//   loaded into the output register, which may still be waiting.
// Reset: async active low; filter unlocked, covariance identity, registers default.
`default_nettype none

// ---------------------------------------------------------------------------
// range_kalman_filter_gated: gated constant-velocity range filter
// Window-based lock, then 2-state Kalman predict/gate/update on one shared
// multiplier and one serial divider.
// ---------------------------------------------------------------------------
module range_kalman_filter_gated
  import rkf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  // configuration
  logic [23:0] tol_q;
  logic [31:0] qn_q, rn_q;
  logic [15:0] gate_q;
  logic [3:0]  warm_q;

  // sequencer
  st_e state_q, state_d;
  op_e op_q, op_d;
  logic mul_start, div_start;

  // filter state
  logic                   locked_q;
  logic signed [31:0]     win_q [WIN_DEPTH];
  logic [WIN_CNT_W-1:0]   fill_q;
  logic signed [31:0]     pos_q, vel_q;
  logic signed [47:0]     p00_q, p01_q, p10_q, p11_q;
  logic [3:0]             supp_q;

  // working registers for one request
  logic        [31:0]     dt_q;
  logic signed [31:0]     d_q, xp_q, lo_q, hi_q, k0_q, k1_q;
  logic signed [47:0]     a00_q, a01_q, a10_q, a11_q, dp11_q, tr_q, thr_q;
  logic        [47:0]     s_q;
  logic signed [32:0]     e_q;
  logic [WIN_IDX_W-1:0]   idx_q;
  logic [1:0]             res_stat_q;
  logic signed [31:0]     res_range_q;
  logic                   out_valid_q;
  out_item_t              out_data_q;

  // shared units
  logic signed [47:0] mul_a, mul_p;
  logic signed [32:0] mul_b;
  logic               mul_sh24, mul_done;
  logic signed [47:0] div_p;
  logic signed [31:0] div_q;
  logic               div_done;

  // datapath comb
  logic signed [32:0] xd, dlo, dhi;
  logic        [32:0] inn_mag, lo_mag, hi_mag;
  logic        [40:0] inn;
  logic               reject, lock_ok;
  logic signed [48:0] s_full;
  logic signed [31:0] win_rd;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= RST_INIT_TOL;
      qn_q   <= RST_PROC_NOISE;
      rn_q   <= RST_MEAS_NOISE;
      gate_q <= RST_GATE;
      warm_q <= RST_WARMUP;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INIT_TOL:    tol_q  <= cfg_data_i[23:0];
        CFG_PROC_NOISE:  qn_q   <= cfg_data_i;
        CFG_MEAS_NOISE:  rn_q   <= cfg_data_i;
        CFG_GATE_FACTOR: gate_q <= cfg_data_i[15:0];
        CFG_WARMUP:      warm_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Multiplier operand select: Q16 products with dt or the gate factor,
  // Q24 products with the gains.
  always_comb begin
    mul_a    = p11_q;
    mul_b    = $signed({1'b0, dt_q});
    mul_sh24 = 1'b0;
    case (op_q)
      OP_DP11: mul_a = p11_q;
      OP_P01:  mul_a = p01_q;
      OP_P10:  mul_a = p10_q;
      OP_DDP:  mul_a = dp11_q;
      OP_VEL:  mul_a = 48'(vel_q);
      OP_THR: begin
        mul_a = tr_q;
        mul_b = $signed({17'd0, gate_q});
      end
      OP_K0E: begin
        mul_a = 48'(e_q); mul_b = 33'(k0_q); mul_sh24 = 1'b1;
      end
      OP_K1E: begin
        mul_a = 48'(e_q); mul_b = 33'(k1_q); mul_sh24 = 1'b1;
      end
      OP_C00: begin
        mul_a = a00_q; mul_b = 33'(k0_q); mul_sh24 = 1'b1;
      end
      OP_C01: begin
        mul_a = a01_q; mul_b = 33'(k0_q); mul_sh24 = 1'b1;
      end
      OP_C10: begin
        mul_a = a00_q; mul_b = 33'(k1_q); mul_sh24 = 1'b1;
      end
      OP_C11: begin
        mul_a = a01_q; mul_b = 33'(k1_q); mul_sh24 = 1'b1;
      end
      default: ;
    endcase
  end

  rkf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh24_i  (mul_sh24),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign div_p = (state_q == S_DIV1) ? a10_q : a00_q;

  rkf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (div_p),
    .s_i     (s_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // Gate: |innovation| in Q24 against gate * trace(P'); a negative threshold
  // always rejects.
  always_comb begin
    xd      = 33'(xp_q) - 33'(d_q);
    inn_mag = xd[32] ? 33'(-xd) : 33'(xd);
    inn     = {inn_mag, 8'd0};
    reject  = thr_q[47] || ({7'd0, inn} > $unsigned(thr_q));
    s_full  = 49'(a00_q) + $signed({17'd0, rn_q});
    win_rd  = win_q[idx_q];
    dlo     = 33'(d_q) - 33'(lo_q);
    dhi     = 33'(d_q) - 33'(hi_q);
    lo_mag  = dlo[32] ? 33'(-dlo) : 33'(dlo);
    hi_mag  = dhi[32] ? 33'(-dhi) : 33'(dhi);
    lock_ok = (lo_mag < {9'd0, tol_q}) && (hi_mag < {9'd0, tol_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_DP11;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (locked_q) begin
            op_d    = OP_DP11;
            state_d = S_MUL;
          end else if (fill_q == WIN_CNT_W'(WIN_DEPTH)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_SCAN: if (idx_q == WIN_IDX_W'(WIN_DEPTH - 1)) state_d = S_LOCK;
      S_LOCK: state_d = S_OUT;
      S_MUL: begin
        mul_start = 1'b1;
        state_d   = S_MWAIT;
      end
      S_MWAIT: begin
        if (mul_done) begin
          state_d = S_MUL;
          case (op_q)
            OP_DP11: op_d = OP_P01;
            OP_P01:  op_d = OP_P10;
            OP_P10:  op_d = OP_DDP;
            OP_DDP:  state_d = S_ADD;
            OP_VEL:  op_d = OP_THR;
            OP_THR:  state_d = S_GATE;
            OP_K0E:  op_d = OP_K1E;
            OP_K1E:  op_d = OP_C00;
            OP_C00:  op_d = OP_C01;
            OP_C01:  op_d = OP_C10;
            OP_C10:  op_d = OP_C11;
            default: state_d = S_OUT;
          endcase
        end
      end
      S_ADD:   state_d = S_TRACE;
      S_TRACE: begin
        op_d    = OP_VEL;
        state_d = S_MUL;
      end
      S_GATE:  state_d = reject ? S_OUT : S_DIV0;
      S_DIV0: begin
        div_start = 1'b1;
        state_d   = S_DWAIT0;
      end
      S_DWAIT0: if (div_done) state_d = S_DIV1;
      S_DIV1: begin
        div_start = 1'b1;
        state_d   = S_DWAIT1;
      end
      S_DWAIT1: begin
        if (div_done) begin
          op_d    = OP_K0E;
          state_d = S_MUL;
        end
      end
      S_OUT: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q <= 1'b0;
      fill_q   <= '0;
      pos_q    <= '0;
      vel_q    <= '0;
      p00_q    <= Q24_ONE;
      p01_q    <= '0;
      p10_q    <= '0;
      p11_q    <= Q24_ONE;
      supp_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !locked_q && fill_q != WIN_CNT_W'(WIN_DEPTH)) begin
            fill_q <= fill_q + 1'b1;
          end
        end
        S_LOCK: begin
          if (lock_ok) begin
            locked_q <= 1'b1;
            pos_q    <= d_q;
            supp_q   <= '0;
          end
        end
        S_GATE: begin
          if (reject) begin
            pos_q  <= xp_q;
            p00_q  <= a00_q;
            p01_q  <= a01_q;
            p10_q  <= a10_q;
            p11_q  <= a11_q;
            supp_q <= warm_q;
          end
        end
        S_MWAIT: begin
          if (mul_done) begin
            case (op_q)
              OP_K0E: pos_q <= sat32(49'(xp_q) + 49'(mul_p));
              OP_K1E: vel_q <= sat32(49'(vel_q) + 49'(mul_p));
              OP_C00: p00_q <= sat48(50'(a00_q) - 50'(mul_p));
              OP_C01: p01_q <= sat48(50'(a01_q) - 50'(mul_p));
              OP_C10: p10_q <= sat48(50'(a10_q) - 50'(mul_p));
              OP_C11: begin
                p11_q <= sat48(50'(a11_q) - 50'(mul_p));
                if (supp_q != 4'd0) supp_q <= supp_q - 4'd1;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Window store, working registers and the result
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          dt_q        <= in_data_i.elapsed_time;
          d_q         <= in_data_i.range_sample;
          res_stat_q  <= STAT_INIT;
          res_range_q <= '0;
          lo_q        <= win_q[0];
          hi_q        <= win_q[0];
          idx_q       <= WIN_IDX_W'(1);
          if (!locked_q && fill_q != WIN_CNT_W'(WIN_DEPTH)) begin
            win_q[fill_q[WIN_IDX_W-1:0]] <= in_data_i.range_sample;
          end
        end
      end
      S_SCAN: begin
        if (win_rd < lo_q) lo_q <= win_rd;
        if (win_rd > hi_q) hi_q <= win_rd;
        idx_q <= idx_q + 1'b1;
      end
      S_LOCK: begin
        if (lock_ok) begin
          res_stat_q  <= STAT_VALID;
          res_range_q <= d_q;
        end else begin
          for (int i = 0; i < WIN_DEPTH - 1; i++) win_q[i] <= win_q[i + 1];
          win_q[WIN_DEPTH - 1] <= d_q;
        end
      end
      S_MWAIT: begin
        if (mul_done) begin
          case (op_q)
            OP_DP11: dp11_q <= mul_p;
            OP_P01:  a00_q  <= sat48(50'(p00_q) + 50'(mul_p));
            OP_P10:  a00_q  <= sat48(50'(a00_q) + 50'(mul_p));
            OP_DDP:  a00_q  <= sat48(50'(a00_q) + 50'(mul_p));
            OP_VEL:  xp_q   <= sat32(49'(pos_q) + 49'(mul_p));
            OP_THR:  thr_q  <= mul_p;
            OP_C11: begin
              // gain products done: either warm-up or a valid estimate
              if (supp_q != 4'd0) begin
                res_stat_q <= STAT_WARMUP;
              end else begin
                res_stat_q  <= STAT_VALID;
                res_range_q <= pos_q;
              end
            end
            default: ;
          endcase
        end
      end
      S_ADD: begin
        a00_q <= sat48(50'(a00_q) + $signed({18'd0, qn_q}));
        a01_q <= sat48(50'(p01_q) + 50'(dp11_q));
        a10_q <= sat48(50'(p10_q) + 50'(dp11_q));
        a11_q <= sat48(50'(p11_q) + $signed({18'd0, qn_q}));
      end
      S_TRACE: tr_q <= sat48(50'(a00_q) + 50'(a11_q));
      S_GATE: begin
        // innovation variance floors at one LSB
        s_q <= (s_full < 49'sd1) ? 48'd1 : s_full[47:0];
        e_q <= 33'(d_q) - 33'(xp_q);
        if (reject) res_stat_q <= STAT_REJECT;
      end
      S_DWAIT0: if (div_done) k0_q <= div_q;
      S_DWAIT1: if (div_done) k1_q <= div_q;
      default: ;
    endcase
  end

  // Output register: loaded when empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      out_data_q.status         <= res_stat_q;
      out_data_q.filtered_range <= res_range_q;
    end
  end

  // Once locked, the filter stays locked until reset
  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    locked_q |=> locked_q)
    else $error("lock dropped");

  // Window fill never passes the depth
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= WIN_CNT_W'(WIN_DEPTH))
    else $error("window overfilled");

  // A valid estimate is only reported by a locked filter
  a_valid_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == STAT_VALID) |-> locked_q)
    else $error("valid result while unlocked");

  // The multiplier only finishes while the sequencer is waiting on it
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == S_MWAIT))
    else $error("multiplier result not consumed");

endmodule

`default_nettype wire

@@ dv/tb_range_kalman_filter_gated.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_range_kalman_filter_gated: self-checking bench for the gated range filter
// Drives range requests and register writes over valid/ready, predicts each
// result with a behavioral fixed-point filter model, and checks every result
// against the oldest pending prediction under random stalls on both sides.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_range_kalman_filter_gated;
  import rkf_pkg::*;

  localparam longint S48_HI = (64'sd1 <<< 47) - 1;
  localparam longint S48_LO = -(64'sd1 <<< 47);
  localparam int     HOLD_CYCLES = 400;
  localparam int     DRAIN_CYCLES = 200;

  // DUT-facing signals; the driven ones are known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Filter model state
  logic [23:0] m_tol;
  logic [31:0] m_qn;
  logic [31:0] m_rn;
  logic [15:0] m_gate;
  logic [3:0]  m_warm;
  bit          m_locked;
  longint      m_win[WIN_DEPTH];
  int          m_fill;
  longint      m_pos;
  longint      m_vel;
  longint      m_cov[4];
  int          m_sup;

  out_item_t   pending_results[$];
  int          err_count = 0;
  bit          idle_on = 1'b1;   // random gaps on both sides
  bit          hold_request = 1'b0;

  range_kalman_filter_gated u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // -------------------------------------------------------------------------
  // Fixed-point helpers
  // -------------------------------------------------------------------------
  function automatic longint clip48(input longint v);
    if (v > S48_HI) return S48_HI;
    if (v < S48_LO) return S48_LO;
    return v;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Exact product, shifted with round half away from zero, clamped to 48 bits
  function automatic longint mul_round(input longint a, input longint b, input int sh);
    logic [127:0] ma, mb, m, lim;
    bit neg;
    ma  = (a < 0) ? 128'(-a) : 128'(a);
    mb  = (b < 0) ? 128'(-b) : 128'(b);
    neg = (a < 0) != (b < 0);
    m   = (ma * mb + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Q.24 ratio p/s, truncated toward zero, magnitude clamped
  function automatic longint kal_gain(input longint p, input longint s);
    logic [127:0] mp, us, q;
    mp = (p < 0) ? 128'(-p) : 128'(p);
    us = 128'(s);
    if (mp >= (us << 7)) q = 128'h7FFF_FFFF;
    else q = (mp << 24) / us;
    return (p < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint magn(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // -------------------------------------------------------------------------
  // Expected result of one request; advances the model state
  // -------------------------------------------------------------------------
  function automatic out_item_t track_range(input logic [31:0] dt_raw,
                                            input logic signed [31:0] smp);
    out_item_t res;
    longint dt, d, lo, hi, dp11, a00, a01, a10, a11, xp, thr, inn, s, k0, k1, e;
    dt  = longint'(dt_raw);
    d   = longint'(smp);
    res = '{status: STAT_INIT, filtered_range: '0};
    if (!m_locked) begin
      if (m_fill >= WIN_DEPTH) begin
        lo = m_win[0];
        hi = m_win[0];
        for (int i = 1; i < WIN_DEPTH; i++) begin
          if (m_win[i] < lo) lo = m_win[i];
          if (m_win[i] > hi) hi = m_win[i];
        end
        // strict compare against both window ends
        if (magn(d - lo) < longint'(m_tol) && magn(d - hi) < longint'(m_tol)) begin
          m_locked = 1'b1;
          m_pos    = d;
          m_sup    = 0;
          res      = '{status: STAT_VALID, filtered_range: smp};
        end else begin
          for (int i = 0; i < WIN_DEPTH - 1; i++) m_win[i] = m_win[i + 1];
          m_win[WIN_DEPTH - 1] = d;
        end
      end else begin
        m_win[m_fill] = d;
        m_fill++;
      end
      return res;
    end
    // predict
    dp11 = mul_round(m_cov[3], dt, 16);
    a00  = clip48(m_cov[0] + mul_round(m_cov[1], dt, 16));
    a00  = clip48(a00 + mul_round(m_cov[2], dt, 16));
    a00  = clip48(a00 + mul_round(dp11, dt, 16));
    a00  = clip48(a00 + longint'(m_qn));
    a01  = clip48(m_cov[1] + dp11);
    a10  = clip48(m_cov[2] + dp11);
    a11  = clip48(m_cov[3] + longint'(m_qn));
    xp   = clip32(m_pos + mul_round(m_vel, dt, 16));
    // gate on innovation vs. scaled trace
    thr  = mul_round(clip48(a00 + a11), longint'(m_gate), 16);
    inn  = magn(xp - d) <<< 8;
    if (inn > thr) begin
      m_pos = xp;
      m_cov = '{a00, a01, a10, a11};
      m_sup = int'(m_warm);
      res.status = STAT_REJECT;
      return res;
    end
    s = a00 + longint'(m_rn);
    if (s < 1) s = 1;   // degenerate innovation variance
    k0 = kal_gain(a00, s);
    k1 = kal_gain(a10, s);
    e  = d - xp;
    m_pos    = clip32(xp + mul_round(e, k0, 24));
    m_vel    = clip32(m_vel + mul_round(e, k1, 24));
    m_cov[0] = clip48(a00 - mul_round(a00, k0, 24));
    m_cov[1] = clip48(a01 - mul_round(a01, k0, 24));
    m_cov[2] = clip48(a10 - mul_round(a00, k1, 24));
    m_cov[3] = clip48(a11 - mul_round(a01, k1, 24));
    if (m_sup > 0) begin
      m_sup--;
      res.status = STAT_WARMUP;
    end else begin
      res.status         = STAT_VALID;
      res.filtered_range = 32'(m_pos);
    end
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Driver tasks (entered and left just after a falling edge)
  // -------------------------------------------------------------------------
  task automatic send_sample(input logic [31:0] dt, input logic [31:0] smp);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{elapsed_time: dt, range_sample: smp};
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, track_range(dt, smp)};
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INIT_TOL:    m_tol  = val[23:0];
      CFG_PROC_NOISE:  m_qn   = val;
      CFG_MEAS_NOISE:  m_rn   = val;
      CFG_GATE_FACTOR: m_gate = val[15:0];
      CFG_WARMUP:      m_warm = val[3:0];
      default: ;  // unmapped index, ignored
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Block is idle once every result is in and the longest request has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Sample close to the current predicted position
  function automatic logic [31:0] near_sample(input logic [31:0] dt, input int spread);
    longint xp;
    xp = clip32(m_pos + mul_round(m_vel, longint'(dt), 16));
    return 32'(clip32(xp + longint'($urandom_range(0, 2 * spread)) - spread));
  endfunction

  function automatic logic [31:0] rand_dt();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(1, 1 << 17);
    if (pick < 8) return $urandom_range(1, 16);
    return $urandom | 32'd1;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // Window fill with extremes under zero tolerance, then lock at max tolerance
  task automatic test_window_lock();
    logic [31:0] extremes[6];
    extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                 32'h5555_5555, 32'hAAAA_AAAA};
    write_reg(CFG_INIT_TOL, 32'd0);
    foreach (extremes[i]) send_sample($urandom | 32'd1, extremes[i]);
    send_sample(32'hFFFF_FFFF, 32'h0000_1000);   // full window, no lock
    wait_idle();
    write_reg(CFG_INIT_TOL, 32'h00FF_FFFF);
    // the last of these locks once the extremes have left the window
    for (int i = 0; i < 6; i++) send_sample(32'h0001_0000, 32'h0010_0000 + 32'(i << 12));
    send_sample(32'h0000_0001, 32'h0010_2000);   // first locked request
  endtask

  // Rejection, warm-up suppression and a closed gate
  task automatic test_gate_cases();
    wait_idle();
    write_reg(CFG_WARMUP, 32'd2);
    write_reg(CFG_GATE_FACTOR, 32'd65535);
    send_sample(32'h0001_0000, near_sample(32'h0001_0000, 16));
    send_sample(32'h0001_0000, near_sample(32'h0001_0000, 16));
    send_sample(32'h0000_8000, 32'h8000_0000);   // far outlier
    for (int i = 0; i < 3; i++) send_sample(32'h0001_0000, near_sample(32'h0001_0000, 16));
    wait_idle();
    write_reg(CFG_GATE_FACTOR, 32'd0);           // any nonzero innovation rejects
    send_sample(32'h0001_0000, near_sample(32'h0001_0000, 0) + 32'd1);
  endtask

  task automatic test_random_phase(input logic [31:0] tol, input logic [31:0] qn,
                                   input logic [31:0] rn, input logic [31:0] gate,
                                   input logic [31:0] warm, input bit gaps,
                                   input bit pressure, input int count);
    logic [31:0] dt;
    wait_idle();
    write_reg(CFG_INIT_TOL, tol);
    write_reg(CFG_PROC_NOISE, qn);
    write_reg(CFG_MEAS_NOISE, rn);
    write_reg(CFG_GATE_FACTOR, gate);
    write_reg(CFG_WARMUP, warm);
    idle_on = gaps;
    if (pressure) hold_request = 1'b1;
    for (int i = 0; i < count; i++) begin
      dt = rand_dt();
      if ($urandom_range(0, 9) < 8) send_sample(dt, near_sample(dt, $urandom_range(0, 1 << 16)));
      else send_sample(dt, $urandom);
    end
  endtask

  // -------------------------------------------------------------------------
  // Result checker: oldest prediction against each accepted result
  // -------------------------------------------------------------------------
  initial begin
    out_item_t want;
    int stall;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall = HOLD_CYCLES;   // long hold-off so the input side backs up
      end else begin
        stall = idle_on ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d range=%h", $time,
                 out_data.status, out_data.filtered_range);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d", $time,
                   want.status, out_data.status);
          err_count++;
        end
        if (out_data.filtered_range !== want.filtered_range) begin
          $display("%0t: range mismatch expected %h actual %h", $time,
                   want.filtered_range, out_data.filtered_range);
          err_count++;
        end
      end
      @(negedge clk);
    end
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    m_tol    = RST_INIT_TOL;
    m_qn     = RST_PROC_NOISE;
    m_rn     = RST_MEAS_NOISE;
    m_gate   = RST_GATE;
    m_warm   = RST_WARMUP;
    m_locked = 1'b0;
    m_fill   = 0;
    m_pos    = 0;
    m_vel    = 0;
    m_cov    = '{64'(Q24_ONE), 0, 0, 64'(Q24_ONE)};
    m_sup    = 0;
    foreach (m_win[i]) m_win[i] = 0;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_window_lock();
    test_gate_cases();
    test_random_phase(32'd0, 32'd1677722, 32'd1, 32'd65535, 32'd0, 1'b1, 1'b0, 145);
    test_random_phase(32'h00FF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd6554, 32'd15,
                      1'b1, 1'b0, 145);
    wait_idle();
    write_reg(3'd7, $urandom);   // unmapped register index
    test_random_phase(32'd65536, 32'hFFFF_FFFF, 32'd167772160, 32'd0, 32'd3,
                      1'b1, 1'b0, 145);
    test_random_phase($urandom, $urandom, $urandom | 32'd1, $urandom, $urandom,
                      1'b0, 1'b0, 145);
    test_random_phase($urandom, $urandom_range(0, 1 << 24), $urandom | 32'd1,
                      $urandom_range(1000, 65535), $urandom, 1'b1, 1'b1, 145);

    wait_idle();
    if (err_count == 0) begin
      $display("tb_range_kalman_filter_gated passed");
    end else begin
      $display("tb_range_kalman_filter_gated failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("tb_range_kalman_filter_gated failed");
    $finish;
  end

endmodule

`default_nettype wire
